FILE: rtl/core/ssi_encoder_reader_speed_macros.svh
// Assertion helpers shared by the encoder reader modules.
`ifndef SSI_ENCODER_READER_SPEED_MACROS_SVH
`define SSI_ENCODER_READER_SPEED_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/ssi_pkg.sv
`timescale 1ns / 1ps

package ssi_pkg;

   // Field widths.
   localparam int POS_W     = 16;
   localparam int CPS_W     = 18;
   localparam int ELAPSED_W = 32;
   localparam int LIMIT_W   = 8;
   localparam int BITS_W    = 5;

   // Speed arithmetic.
   localparam int MS_PER_SEC = 1000;
   localparam int DIV_STEPS  = CPS_W;
   localparam int STEP_W     = $clog2(DIV_STEPS + 1);

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = LIMIT_W;

   localparam logic [BITS_W-1:0]  BIT_COUNT_RESET    = 5'd10;
   localparam logic [LIMIT_W-1:0] GLITCH_LIMIT_RESET = 8'd30;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_BIT_COUNT    = 1'b0,
      REG_GLITCH_LIMIT = 1'b1
   } csr_reg_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LOW,
      PH_HIGH,
      PH_DONE
   } phase_type;

   typedef enum logic [0:0] {
      BK_IDLE,
      BK_DIV
   } back_state_type;

   // One classified transaction, as handed from the front to the back.
   typedef struct packed {
      logic                 chip_select_n;
      logic                 serial_clock;
      logic                 done_res;
      logic                 glitch;
      logic [POS_W-1:0]     position;
      logic [POS_W-1:0]     delta;
      logic [ELAPSED_W-1:0] elapsed;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: rtl/core/ssi_queue.sv
`timescale 1ns / 1ps
`include "ssi_encoder_reader_speed_macros.svh"

module ssi_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ssi_pkg::job_type          push_data,
   input  logic                      pop,
   output ssi_pkg::job_type          pop_data,
   output ssi_pkg::queue_status_type status
);

   ssi_pkg::job_type                 entries_ff [ssi_pkg::QUEUE_DEPTH];
   logic [ssi_pkg::QPTR_W-1:0]       wr_ptr_ff;
   logic [ssi_pkg::QPTR_W-1:0]       rd_ptr_ff;
   logic [ssi_pkg::QCNT_W-1:0]       count_ff;
   logic [ssi_pkg::QPTR_W-1:0]       wr_ptr_in;
   logic [ssi_pkg::QPTR_W-1:0]       rd_ptr_in;
   logic [ssi_pkg::QCNT_W-1:0]       count_in;

   // Status and head of the queue.
   assign status.full  = (count_ff == ssi_pkg::QCNT_W'(ssi_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entries_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `SSI_ASSERT_NOW(a_no_overflow, clock, reset, status.full, !push, "push into full queue")
   `SSI_ASSERT_NOW(a_no_underflow, clock, reset, status.empty, !pop, "pop from empty queue")
   `SSI_ASSERT_NOW(a_empty_ptrs, clock, reset, status.empty, wr_ptr_ff == rd_ptr_ff, "pointers apart while empty")

endmodule

FILE: rtl/core/ssi_front.sv
`timescale 1ns / 1ps

module ssi_front #(
   parameter int MAX_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [ssi_pkg::BITS_W-1:0]   bit_count,
   input  logic [ssi_pkg::LIMIT_W-1:0]  glitch_limit,
   input  logic                         accept,
   input  logic                         start_read,
   input  logic                         serial_data,
   input  logic                         ms_tick,
   output ssi_pkg::job_type             job
);

   localparam int IDX_W = $clog2(MAX_BITS + 1);

   ssi_pkg::phase_type                  phase_ff, phase_in;
   logic [IDX_W-1:0]                    bit_index_ff, bit_index_in;
   logic [ssi_pkg::POS_W-1:0]           shift_ff, shift_in;
   logic [ssi_pkg::POS_W-1:0]           prev_pos_ff, prev_pos_in;
   logic [ssi_pkg::ELAPSED_W-1:0]       elapsed_ff, elapsed_in;
   logic [ssi_pkg::ELAPSED_W-1:0]       elapsed_inc;
   logic [IDX_W-1:0]                    eff_bits;
   logic [IDX_W-1:0]                    index_inc;
   logic [ssi_pkg::POS_W-1:0]           mask;
   logic [ssi_pkg::POS_W-1:0]           pos;
   logic [ssi_pkg::POS_W-1:0]           dlt;
   logic                                glt;

   // Effective bit count: zero reads as one, large values clamp to MAX_BITS.
   always_comb begin
      if (bit_count == '0) begin
         eff_bits = IDX_W'(1);
      end else if (32'(bit_count) > 32'(MAX_BITS)) begin
         eff_bits = IDX_W'(MAX_BITS);
      end else begin
         eff_bits = IDX_W'(bit_count);
      end
      if (32'(eff_bits) >= 32'(ssi_pkg::POS_W)) begin
         mask = '1;
      end else begin
         mask = ssi_pkg::POS_W'((32'(1) << eff_bits) - 32'(1));
      end
   end

   // Millisecond counter saturates, and this tick's millisecond counts first.
   assign elapsed_inc = (ms_tick && (elapsed_ff != '1)) ? elapsed_ff + 1'b1 : elapsed_ff;
   assign index_inc   = bit_index_ff + 1'b1;

   // Reading results, meaningful on the done tick.
   assign pos = shift_ff & mask;
   assign dlt = (pos - (prev_pos_ff & mask)) & mask;
   assign glt = (dlt > ssi_pkg::POS_W'(glitch_limit));

   // Sequencer next state and transaction classification.
   always_comb begin
      phase_in          = phase_ff;
      bit_index_in      = bit_index_ff;
      shift_in          = shift_ff;
      prev_pos_in       = prev_pos_ff;
      elapsed_in        = elapsed_inc;
      job.chip_select_n = 1'b1;
      job.serial_clock  = 1'b1;
      job.done_res      = 1'b0;
      job.glitch        = 1'b0;
      job.position      = '0;
      job.delta         = '0;
      job.elapsed       = (elapsed_inc == '0) ? ssi_pkg::ELAPSED_W'(1) : elapsed_inc;
      unique case (phase_ff)
         ssi_pkg::PH_IDLE: begin
            if (start_read) begin
               job.chip_select_n = 1'b0;
               bit_index_in      = '0;
               shift_in          = '0;
               phase_in          = ssi_pkg::PH_LOW;
            end
         end
         ssi_pkg::PH_LOW: begin
            job.chip_select_n = 1'b0;
            job.serial_clock  = 1'b0;
            phase_in          = ssi_pkg::PH_HIGH;
         end
         ssi_pkg::PH_HIGH: begin
            job.chip_select_n = 1'b0;
            shift_in          = {shift_ff[ssi_pkg::POS_W-2:0], serial_data};
            bit_index_in      = index_inc;
            phase_in          = (index_inc >= eff_bits) ? ssi_pkg::PH_DONE : ssi_pkg::PH_LOW;
         end
         ssi_pkg::PH_DONE: begin
            job.done_res = 1'b1;
            job.glitch   = glt;
            job.position = pos;
            job.delta    = dlt;
            if (!glt) begin
               elapsed_in = '0;
            end
            prev_pos_in = pos;
            phase_in    = ssi_pkg::PH_IDLE;
         end
         default: begin
            phase_in = ssi_pkg::PH_IDLE;
         end
      endcase
   end

   // State advances once per accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ssi_pkg::PH_IDLE;
         bit_index_ff <= '0;
         shift_ff     <= '0;
         prev_pos_ff  <= '0;
         elapsed_ff   <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         bit_index_ff <= bit_index_in;
         shift_ff     <= shift_in;
         prev_pos_ff  <= prev_pos_in;
         elapsed_ff   <= elapsed_in;
      end
   end

endmodule

FILE: rtl/core/ssi_back.sv
`timescale 1ns / 1ps
`include "ssi_encoder_reader_speed_macros.svh"

module ssi_back (
   input  logic                         clock,
   input  logic                         reset,
   input  ssi_pkg::queue_status_type    status,
   input  ssi_pkg::job_type             pop_data,
   output logic                         pop,
   input  logic                         rsp_stall,
   output logic                         rsp_valid,
   output logic                         rsp_chip_select_n,
   output logic                         rsp_serial_clock,
   output logic                         rsp_done_res,
   output logic [ssi_pkg::POS_W-1:0]    rsp_position,
   output logic [ssi_pkg::POS_W-1:0]    rsp_delta,
   output logic                         rsp_glitch,
   output logic [ssi_pkg::CPS_W-1:0]    rsp_counts_per_sec
);

   ssi_pkg::back_state_type             state_ff, state_in;
   logic [ssi_pkg::STEP_W-1:0]          step_ff, step_in;
   logic [ssi_pkg::CPS_W-1:0]           quot_ff, quot_in;
   logic [ssi_pkg::ELAPSED_W-1:0]       rem_ff, rem_in;
   logic [ssi_pkg::ELAPSED_W-1:0]       divisor_ff, divisor_in;
   ssi_pkg::job_type                    job_ff, job_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   ssi_pkg::job_type                    out_job_ff, out_job_in;
   logic [ssi_pkg::CPS_W-1:0]           out_cps_ff, out_cps_in;
   logic                                load_out;
   logic                                out_free;
   logic                                need_div;
   logic [ssi_pkg::ELAPSED_W:0]         trial;
   logic [ssi_pkg::ELAPSED_W:0]         diff;
   logic                                fits;
   logic [ssi_pkg::CPS_W-1:0]           dividend;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign need_div = pop_data.done_res && !pop_data.glitch;

   // A good reading has a delta of at most eight bits, so the product fits.
   assign dividend = ssi_pkg::CPS_W'(32'(pop_data.delta[ssi_pkg::LIMIT_W-1:0])
                                     * 32'(ssi_pkg::MS_PER_SEC));

   // One restoring division step: shift in a dividend bit, subtract if it fits.
   assign trial = {rem_ff, quot_ff[ssi_pkg::CPS_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = (trial >= {1'b0, divisor_ff});

   // Dispatch from the queue and divider sequencing.
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      job_in     = job_ff;
      pop        = 1'b0;
      load_out   = 1'b0;
      out_job_in = out_job_ff;
      out_cps_in = out_cps_ff;
      unique case (state_ff)
         ssi_pkg::BK_IDLE: begin
            if (!status.empty) begin
               if (need_div) begin
                  pop        = 1'b1;
                  job_in     = pop_data;
                  quot_in    = dividend;
                  rem_in     = '0;
                  divisor_in = pop_data.elapsed;
                  step_in    = ssi_pkg::STEP_W'(ssi_pkg::DIV_STEPS);
                  state_in   = ssi_pkg::BK_DIV;
               end else if (out_free) begin
                  pop        = 1'b1;
                  load_out   = 1'b1;
                  out_job_in = pop_data;
                  out_cps_in = '0;
               end
            end
         end
         ssi_pkg::BK_DIV: begin
            if (step_ff != '0) begin
               rem_in  = fits ? diff[ssi_pkg::ELAPSED_W-1:0] : trial[ssi_pkg::ELAPSED_W-1:0];
               quot_in = {quot_ff[ssi_pkg::CPS_W-2:0], fits};
               step_in = step_ff - 1'b1;
            end else if (out_free) begin
               load_out   = 1'b1;
               out_job_in = job_ff;
               out_cps_in = quot_ff;
               state_in   = ssi_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = ssi_pkg::BK_IDLE;
         end
      endcase
   end

   // Output register holds a result until the transaction completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssi_pkg::BK_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      job_ff     <= job_in;
      out_job_ff <= out_job_in;
      out_cps_ff <= out_cps_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_chip_select_n  = out_job_ff.chip_select_n;
   assign rsp_serial_clock   = out_job_ff.serial_clock;
   assign rsp_done_res       = out_job_ff.done_res;
   assign rsp_position       = out_job_ff.position;
   assign rsp_delta          = out_job_ff.delta;
   assign rsp_glitch         = out_job_ff.glitch;
   assign rsp_counts_per_sec = out_cps_ff;

   `SSI_ASSERT_NOW(a_no_pop_in_div, clock, reset, state_ff == ssi_pkg::BK_DIV, !pop, "queue popped during division")
   `SSI_ASSERT_NEXT(a_div_runs, clock, reset, (state_ff == ssi_pkg::BK_DIV) && (step_ff != '0), state_ff == ssi_pkg::BK_DIV, "division left early")
   `SSI_ASSERT_NOW(a_idle_step_zero, clock, reset, state_ff == ssi_pkg::BK_IDLE, step_ff == '0, "step count live while idle")

endmodule

FILE: rtl/core/ssi_encoder_reader_speed.sv
`timescale 1ns / 1ps

// Channel  | Ports                                      | Transaction
// ---------+--------------------------------------------+------------------------------
// request  | req_valid, req_stall, req_* fields         | one half-period tick in
// response | rsp_valid, rsp_stall, rsp_* fields         | one pin drive and result out
// csr      | csr_wr_en, csr_index, csr_wdata            | register write, no wait
//
// A tick is classified in the cycle it is accepted; its result passes through the queue
// to the output register. The done tick of a good, non-glitch reading first runs an
// 18-step restoring divider for the speed, and loads the output only when it is free.
// A two-entry queue sits between the sequencer and the divider; req_stall rises when full.
// A stalled response holds in the output register; reset clears state and loads defaults.

module ssi_encoder_reader_speed #(
   parameter int MAX_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_start_read,
   input  logic                              req_serial_data,
   input  logic                              req_ms_tick,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_chip_select_n,
   output logic                              rsp_serial_clock,
   output logic                              rsp_done_res,
   output logic [ssi_pkg::POS_W-1:0]         rsp_position,
   output logic [ssi_pkg::POS_W-1:0]         rsp_delta,
   output logic                              rsp_glitch,
   output logic [ssi_pkg::CPS_W-1:0]         rsp_counts_per_sec,
   input  logic                              csr_wr_en,
   input  logic [ssi_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ssi_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [ssi_pkg::BITS_W-1:0]   bit_count_ff, bit_count_in;
   logic [ssi_pkg::LIMIT_W-1:0]  glitch_limit_ff, glitch_limit_in;
   logic                         accept;
   logic                         pop;
   ssi_pkg::job_type             push_job;
   ssi_pkg::job_type             pop_job;
   ssi_pkg::queue_status_type    status;

   // Configuration register writes.
   always_comb begin
      bit_count_in    = bit_count_ff;
      glitch_limit_in = glitch_limit_ff;
      if (csr_wr_en) begin
         unique case (ssi_pkg::csr_reg_type'(csr_index))
            ssi_pkg::REG_BIT_COUNT:    bit_count_in    = csr_wdata[ssi_pkg::BITS_W-1:0];
            ssi_pkg::REG_GLITCH_LIMIT: glitch_limit_in = csr_wdata;
            default: begin
               bit_count_in = bit_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff    <= ssi_pkg::BIT_COUNT_RESET;
         glitch_limit_ff <= ssi_pkg::GLITCH_LIMIT_RESET;
      end else begin
         bit_count_ff    <= bit_count_in;
         glitch_limit_ff <= glitch_limit_in;
      end
   end

   // Request handshake.
   assign req_stall = status.full;
   assign accept    = req_valid && !status.full;

   ssi_front #(
      .MAX_BITS (MAX_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .bit_count    (bit_count_ff),
      .glitch_limit (glitch_limit_ff),
      .accept       (accept),
      .start_read   (req_start_read),
      .serial_data  (req_serial_data),
      .ms_tick      (req_ms_tick),
      .job          (push_job)
   );

   ssi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (push_job),
      .pop       (pop),
      .pop_data  (pop_job),
      .status    (status)
   );

   ssi_back u_back (
      .clock              (clock),
      .reset              (reset),
      .status             (status),
      .pop_data           (pop_job),
      .pop                (pop),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_chip_select_n  (rsp_chip_select_n),
      .rsp_serial_clock   (rsp_serial_clock),
      .rsp_done_res       (rsp_done_res),
      .rsp_position       (rsp_position),
      .rsp_delta          (rsp_delta),
      .rsp_glitch         (rsp_glitch),
      .rsp_counts_per_sec (rsp_counts_per_sec)
   );

endmodule
